FILE: rtl/gpp_pkg.sv
// Shared types and constants for the grid point projector with bounding box.
package gpp_pkg;

   localparam int COORD_WIDTH_DEF     = 16;
   localparam int SCALE_FRAC_BITS_DEF = 8;

   localparam int OUT_WIDTH      = 32;
   localparam int SCALE_WIDTH    = 16;
   localparam int VIEW_WIDTH     = 3;
   localparam int TURN_WIDTH     = 2;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_IDX_WIDTH  = 2;

   // register indexes, byte address is 4 * index
   localparam logic [REG_IDX_WIDTH-1:0] REG_VIEW_MODE     = 2'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_SCALE         = 2'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_QUARTER_TURNS = 2'd2;

   // view mode codes; codes above PROJ_REAR project to the origin
   localparam logic [VIEW_WIDTH-1:0] PROJ_ISOMETRIC = 3'd0;
   localparam logic [VIEW_WIDTH-1:0] PROJ_PLAN      = 3'd1;
   localparam logic [VIEW_WIDTH-1:0] PROJ_PROFILE   = 3'd2;
   localparam logic [VIEW_WIDTH-1:0] PROJ_FRONT     = 3'd3;
   localparam logic [VIEW_WIDTH-1:0] PROJ_REAR      = 3'd4;

   localparam logic [VIEW_WIDTH-1:0]  VIEW_MODE_RESET     = PROJ_ISOMETRIC;
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET         = 16'd256;
   localparam logic [TURN_WIDTH-1:0]  QUARTER_TURNS_RESET = 2'd0;

   typedef struct packed {
      logic [VIEW_WIDTH-1:0]  view_mode;
      logic [SCALE_WIDTH-1:0] scale;
      logic [TURN_WIDTH-1:0]  quarter_turns;
   } cfg_type;

endpackage

FILE: rtl/grid_point_projector_bbox_unit.sv
// Top level: grid point projector with running bounding box.
//
// Usage:
//   The req channel takes one grid point (x, y, height, first_of_frame) per
//   transaction; the rsp channel returns the projected screen point and the
//   bounding box of the frame so far. Both are valid/ready channels.
//   The APB-style port sets view mode (0x0), Q8.8 scale (0x4) and quarter
//   turns (0x8); pready is always high. Write it only while the block idles.
//   A req transaction passes through the input register, then the result
//   register, before rsp_valid rises. Throughput: one transaction per cycle
//   while rsp_ready holds, set by the input register feeding the projection
//   multipliers, saturation and box compare into the result register.
//   The result register also holds the box state, so the box only advances
//   as results are registered, in order.
//   Reset: synchronous, clears both stage valids, the box to zero and the
//   registers to view 0, scale 1.0, no turns. req_ready is high after reset.
//   Stall: while rsp_ready is low the result holds; one more transaction is
//   taken into the input register, then req_ready drops until rsp moves.
module grid_point_projector_bbox_unit #(
   parameter int COORD_WIDTH     = gpp_pkg::COORD_WIDTH_DEF,
   parameter int SCALE_FRAC_BITS = gpp_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_grid_x,
   input  logic signed [COORD_WIDTH-1:0]       req_grid_y,
   input  logic signed [COORD_WIDTH-1:0]       req_height_z,
   input  logic                                req_first_of_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_screen_x,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_screen_y,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_left,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_right,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_top,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_bottom,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gpp_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [gpp_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [gpp_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   import gpp_pkg::*;

   cfg_type cfg;

   logic                          in_valid_ff, in_valid_in;
   logic signed [COORD_WIDTH-1:0] gx_ff, gy_ff, gz_ff;
   logic                          first_ff;

   logic                          out_valid_ff, out_valid_in;
   logic signed [OUT_WIDTH-1:0]   sx_ff, sy_ff;
   logic signed [OUT_WIDTH-1:0]   left_ff, right_ff, top_ff, bottom_ff;
   logic signed [OUT_WIDTH-1:0]   left_in, right_in, top_in, bottom_in;

   logic signed [OUT_WIDTH-1:0]   sx, sy;
   logic                          in_ready, out_ready, in_load, out_load;

   gpp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gpp_project #(
      .COORD_WIDTH     (COORD_WIDTH),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_project (
      .cfg      (cfg),
      .grid_x   (gx_ff),
      .grid_y   (gy_ff),
      .height_z (gz_ff),
      .screen_x (sx),
      .screen_y (sy)
   );

   assign out_ready = !out_valid_ff || rsp_ready;
   assign in_ready  = !in_valid_ff || out_ready;
   assign in_load   = req_valid && in_ready;
   assign out_load  = in_valid_ff && out_ready;

   assign in_valid_in  = in_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   // a frame start replaces the box; otherwise the point is merged in
   always_comb begin
      if (first_ff) begin
         left_in   = sx;
         right_in  = sx;
         top_in    = sy;
         bottom_in = sy;
      end else begin
         left_in   = (sx < left_ff)   ? sx : left_ff;
         right_in  = (sx > right_ff)  ? sx : right_ff;
         top_in    = (sy < top_ff)    ? sy : top_ff;
         bottom_in = (sy > bottom_ff) ? sy : bottom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
         top_ff       <= '0;
         bottom_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            left_ff   <= left_in;
            right_ff  <= right_in;
            top_ff    <= top_in;
            bottom_ff <= bottom_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         gx_ff    <= req_grid_x;
         gy_ff    <= req_grid_y;
         gz_ff    <= req_height_z;
         first_ff <= req_first_of_frame;
      end
      if (out_load) begin
         sx_ff <= sx;
         sy_ff <= sy;
      end
   end

   assign req_ready      = in_ready;
   assign rsp_valid      = out_valid_ff;
   assign rsp_screen_x   = sx_ff;
   assign rsp_screen_y   = sy_ff;
   assign rsp_box_left   = left_ff;
   assign rsp_box_right  = right_ff;
   assign rsp_box_top    = top_ff;
   assign rsp_box_bottom = bottom_ff;

endmodule

FILE: rtl/gpp_csr.sv
// APB-style configuration register file for the projector.
module gpp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gpp_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [gpp_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [gpp_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output gpp_pkg::cfg_type                    cfg
);
   import gpp_pkg::*;

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic                     wr_en;
   logic [REG_IDX_WIDTH-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_VIEW_MODE:     cfg_in.view_mode     = pwdata[VIEW_WIDTH-1:0];
            REG_SCALE:         cfg_in.scale         = pwdata[SCALE_WIDTH-1:0];
            REG_QUARTER_TURNS: cfg_in.quarter_turns = pwdata[TURN_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_VIEW_MODE:     prdata = CSR_DATA_WIDTH'(cfg_ff.view_mode);
         REG_SCALE:         prdata = CSR_DATA_WIDTH'(cfg_ff.scale);
         REG_QUARTER_TURNS: prdata = CSR_DATA_WIDTH'(cfg_ff.quarter_turns);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_mode     <= VIEW_MODE_RESET;
         cfg_ff.scale         <= SCALE_RESET;
         cfg_ff.quarter_turns <= QUARTER_TURNS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/gpp_project.sv
// Quarter turns, view projection, fixed-point scaling and 32-bit saturation.
module gpp_project #(
   parameter int COORD_WIDTH     = gpp_pkg::COORD_WIDTH_DEF,
   parameter int SCALE_FRAC_BITS = gpp_pkg::SCALE_FRAC_BITS_DEF
) (
   input  gpp_pkg::cfg_type                      cfg,
   input  logic signed [COORD_WIDTH-1:0]         grid_x,
   input  logic signed [COORD_WIDTH-1:0]         grid_y,
   input  logic signed [COORD_WIDTH-1:0]         height_z,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0]  screen_x,
   output logic signed [gpp_pkg::OUT_WIDTH-1:0]  screen_y
);
   import gpp_pkg::*;

   // numerator: x + y - 2z needs three bits over the coordinate width
   localparam int NW = COORD_WIDTH + 3;
   localparam int PW = NW + SCALE_WIDTH + 1;
   localparam int EW = (PW > OUT_WIDTH + 1) ? PW : OUT_WIDTH + 1;

   logic signed [NW-1:0] x0, y0, z0;
   logic signed [NW-1:0] xt, yt;
   logic signed [NW-1:0] num_x, num_y;
   logic                 half_y;
   logic signed [PW-1:0] prod_x, prod_y;
   logic signed [PW-1:0] scale_ext;

   // divide by 2^(F + extra) rounding toward zero
   function automatic logic signed [PW-1:0] trunc_div(input logic signed [PW-1:0] p,
                                                      input logic extra);
      logic        [PW-1:0] bias;
      logic signed [PW-1:0] sum;
      bias = p[PW-1] ? ((PW'(1) << (SCALE_FRAC_BITS + int'(extra))) - PW'(1)) : '0;
      sum  = p + $signed(bias);
      return sum >>> (SCALE_FRAC_BITS + int'(extra));
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [PW-1:0] q);
      logic signed [EW-1:0] qe;
      logic                 fits;
      qe   = EW'(q);
      fits = (qe[EW-1:OUT_WIDTH-1] == '0) || (qe[EW-1:OUT_WIDTH-1] == '1);
      if (fits) begin
         return qe[OUT_WIDTH-1:0];
      end else if (qe[EW-1]) begin
         return {1'b1, {(OUT_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_WIDTH-1){1'b1}}};
      end
   endfunction

   assign x0 = NW'(grid_x);
   assign y0 = NW'(grid_y);
   assign z0 = NW'(height_z);

   // each left turn maps (x, y) to (y, -x)
   always_comb begin
      unique case (cfg.quarter_turns)
         2'd0: begin
            xt = x0;
            yt = y0;
         end
         2'd1: begin
            xt = y0;
            yt = -x0;
         end
         2'd2: begin
            xt = -x0;
            yt = -y0;
         end
         default: begin
            xt = -y0;
            yt = x0;
         end
      endcase
   end

   always_comb begin
      half_y = 1'b0;
      unique case (cfg.view_mode)
         PROJ_ISOMETRIC: begin
            num_x  = xt - yt;
            num_y  = xt + yt - (z0 + z0);
            half_y = 1'b1;
         end
         PROJ_PLAN: begin
            num_x = xt;
            num_y = -yt;
         end
         PROJ_PROFILE: begin
            num_x = yt;
            num_y = -z0;
         end
         PROJ_FRONT: begin
            num_x = xt;
            num_y = -z0;
         end
         PROJ_REAR: begin
            num_x = -xt;
            num_y = -z0;
         end
         default: begin
            num_x = '0;
            num_y = '0;
         end
      endcase
   end

   assign scale_ext = $signed(PW'(cfg.scale));
   assign prod_x    = PW'(num_x) * scale_ext;
   assign prod_y    = PW'(num_y) * scale_ext;

   assign screen_x = sat_out(trunc_div(prod_x, 1'b0));
   assign screen_y = sat_out(trunc_div(prod_y, half_y));

endmodule

FILE: rtl/gpp_checker.sv
// Port-level assertions for the projector, bound to the top level.
module gpp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_screen_x,
   input logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_screen_y,
   input logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_left,
   input logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_right,
   input logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_top,
   input logic signed [gpp_pkg::OUT_WIDTH-1:0] rsp_box_bottom
);
   import gpp_pkg::*;

   // a stalled result holds, box included
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x) &&
      $stable(rsp_screen_y) && $stable(rsp_box_left) && $stable(rsp_box_right) &&
      $stable(rsp_box_top) && $stable(rsp_box_bottom))
      else $error("rsp transaction changed while stalled");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_box_left <= rsp_box_right) && (rsp_box_top <= rsp_box_bottom))
      else $error("bounding box edges out of order");

   // the point just emitted always lies inside the box sent with it
   a_point_in_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_screen_x >= rsp_box_left) && (rsp_screen_x <= rsp_box_right) &&
      (rsp_screen_y >= rsp_box_top) && (rsp_screen_y <= rsp_box_bottom))
      else $error("screen point outside its bounding box");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind grid_point_projector_bbox_unit gpp_checker u_gpp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_screen_x   (rsp_screen_x),
   .rsp_screen_y   (rsp_screen_y),
   .rsp_box_left   (rsp_box_left),
   .rsp_box_right  (rsp_box_right),
   .rsp_box_top    (rsp_box_top),
   .rsp_box_bottom (rsp_box_bottom)
);
